### rtl/aids_pkg.sv
// ----------------------------------------------------------------------------
// aids_pkg
// Shared types and constants for the packed array insert/delete/search block.
// ----------------------------------------------------------------------------
package aids_pkg;

    // Number of words the array can hold.
    localparam int CAPACITY = 16;

    // Internal widths that follow from the capacity.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Fixed port widths.
    localparam int OPC_W   = 2;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 4;
    localparam int STAT_W  = 2;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;

    // Width used to compare an insertion position against the count.
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    // Depth of the command queue between the front and back parts.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Operation codes.
    typedef enum logic [OPC_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_SEARCH   = 2'd2,
        OP_TRAVERSE = 2'd3
    } op_t;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    // One decoded command as it sits in the queue.
    typedef struct packed {
        op_t                       op;
        logic signed [DATA_W-1:0]  value;
        logic        [POS_W-1:0]   position;
    } cmd_t;

endpackage

### rtl/aids_front.sv
// ----------------------------------------------------------------------------
// aids_front
// Accepts input beats, decodes the opcode and buffers commands in a short
// queue so that the back part can stall independently of the sender.
// ----------------------------------------------------------------------------
module aids_front
    import aids_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [OPC_W-1:0]          opcode,
    input  logic signed [DATA_W-1:0]  value,
    input  logic [POS_W-1:0]          position,
    output logic                      cmd_valid,
    input  logic                      cmd_ready,
    output cmd_t                      cmd
);

    cmd_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;
    logic              push;
    logic              pop;
    cmd_t              decoded;

    // Classify the incoming beat into a queue entry.
    always_comb
    begin
        decoded.op       = op_t'(opcode);
        decoded.value    = value;
        decoded.position = position;
    end

    assign in_ready  = (fill_reg != QCNT_W'(QDEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/aids_back.sv
// ----------------------------------------------------------------------------
// aids_back
// Carries out queued commands against the entry memory, one at a time, and
// presents results through an output register.
// ----------------------------------------------------------------------------
module aids_back
    import aids_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_ready,
    input  cmd_t                      cmd,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [STAT_W-1:0]         status,
    output logic [INDEX_W-1:0]        index,
    output logic signed [DATA_W-1:0]  element,
    output logic [COUNT_W-1:0]        count,
    output logic                      last
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DEL_RD,
        S_DEL_WR,
        S_TRV_RD,
        S_TRV_EMIT,
        S_FINISH
    } state_t;

    // Entry memory with one write and one registered read port.
    logic signed [DATA_W-1:0] mem [CAPACITY];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;

    state_t                   state_reg, state_next;
    op_t                      op_reg, op_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         ptr_reg, ptr_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic [STAT_W-1:0]        fin_status_reg, fin_status_next;
    logic [CNT_W-1:0]         fin_index_reg, fin_index_next;
    logic signed [DATA_W-1:0] fin_elem_reg, fin_elem_next;
    logic                     out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]        out_status_reg, out_status_next;
    logic [INDEX_W-1:0]       out_index_reg, out_index_next;
    logic signed [DATA_W-1:0] out_elem_reg, out_elem_next;
    logic [COUNT_W-1:0]       out_count_reg, out_count_next;
    logic                     out_last_reg, out_last_next;

    logic                     out_free;
    logic [CNT_W-1:0]         ptr_inc;
    logic [CNT_W-1:0]         ptr_dec;
    logic [CMP_W-1:0]         pos_cmp;
    logic [CMP_W-1:0]         cnt_cmp;

    assign out_free = !out_valid_reg || out_ready;
    assign ptr_inc  = ptr_reg + 1'b1;
    assign ptr_dec  = ptr_reg - 1'b1;
    assign pos_cmp  = CMP_W'(cmd.position);
    assign cnt_cmp  = CMP_W'(cnt_reg);

    // Memory ports.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Sequencer: next state, memory controls and result loading.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        cnt_next        = cnt_reg;
        ptr_next        = ptr_reg;
        pos_next        = pos_reg;
        fin_status_next = fin_status_reg;
        fin_index_next  = fin_index_reg;
        fin_elem_next   = fin_elem_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_elem_next   = out_elem_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        cmd_ready       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    op_next  = cmd.op;
                    val_next = cmd.value;
                    ptr_next = '0;
                    unique case (cmd.op) inside
                        OP_INSERT:
                        begin
                            if (cnt_reg == CNT_W'(CAPACITY))
                            begin
                                fin_status_next = ST_FULL;
                                fin_index_next  = '0;
                                fin_elem_next   = '0;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                // A position at or past the count appends.
                                pos_next = (pos_cmp > cnt_cmp) ? cnt_reg : CNT_W'(pos_cmp);
                                ptr_next = cnt_reg;
                                if (pos_cmp >= cnt_cmp)
                                begin
                                    state_next = S_INS_PUT;
                                end
                                else
                                begin
                                    state_next = S_INS_RD;
                                end
                            end
                        end
                        OP_DELETE, OP_SEARCH:
                        begin
                            if (cnt_reg == '0)
                            begin
                                fin_status_next = ST_NOTFOUND;
                                fin_index_next  = '0;
                                fin_elem_next   = '0;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_SRCH_RD;
                            end
                        end
                        default:
                        begin
                            if (cnt_reg == '0)
                            begin
                                fin_status_next = ST_EMPTY;
                                fin_index_next  = '0;
                                fin_elem_next   = '0;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_TRV_RD;
                            end
                        end
                    endcase
                end
            end

            // Shift entries up one place, from the top down to the slot.
            S_INS_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = ptr_dec[IDX_W-1:0];
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg[IDX_W-1:0];
                mem_wdata = rd_data_reg;
                ptr_next  = ptr_dec;
                if (ptr_dec == pos_reg)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    state_next = S_INS_RD;
                end
            end
            S_INS_PUT:
            begin
                mem_we          = 1'b1;
                mem_waddr       = pos_reg[IDX_W-1:0];
                mem_wdata       = val_reg;
                cnt_next        = cnt_reg + 1'b1;
                fin_status_next = ST_OK;
                fin_index_next  = pos_reg;
                fin_elem_next   = val_reg;
                state_next      = S_FINISH;
            end

            // Linear scan for the first entry equal to the value.
            S_SRCH_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = ptr_reg[IDX_W-1:0];
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (rd_data_reg == val_reg)
                begin
                    fin_status_next = ST_OK;
                    fin_index_next  = ptr_reg;
                    fin_elem_next   = rd_data_reg;
                    if (op_reg == OP_SEARCH)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_DEL_RD;
                    end
                end
                else if (ptr_inc == cnt_reg)
                begin
                    fin_status_next = ST_NOTFOUND;
                    fin_index_next  = '0;
                    fin_elem_next   = '0;
                    state_next      = S_FINISH;
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_SRCH_RD;
                end
            end

            // Close the gap left by the deleted entry.
            S_DEL_RD:
            begin
                if (ptr_inc >= cnt_reg)
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_inc[IDX_W-1:0];
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg[IDX_W-1:0];
                mem_wdata  = rd_data_reg;
                ptr_next   = ptr_inc;
                state_next = S_DEL_RD;
            end

            // Emit each live entry in order.
            S_TRV_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = ptr_reg[IDX_W-1:0];
                state_next = S_TRV_EMIT;
            end
            S_TRV_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_index_next  = INDEX_W'(ptr_reg);
                    out_elem_next   = rd_data_reg;
                    out_count_next  = COUNT_W'(cnt_reg);
                    out_last_next   = (ptr_inc == cnt_reg);
                    ptr_next        = ptr_inc;
                    if (ptr_inc == cnt_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_TRV_RD;
                    end
                end
            end

            // Single result of insert, delete, search or empty traverse.
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = fin_status_reg;
                    out_index_next  = INDEX_W'(fin_index_reg);
                    out_elem_next   = fin_elem_reg;
                    out_count_next  = COUNT_W'(cnt_reg);
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        ptr_reg        <= ptr_next;
        pos_reg        <= pos_next;
        fin_status_reg <= fin_status_next;
        fin_index_reg  <= fin_index_next;
        fin_elem_reg   <= fin_elem_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_elem_reg   <= out_elem_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign index     = out_index_reg;
    assign element   = out_elem_reg;
    assign count     = out_count_reg;
    assign last      = out_last_reg;

    // The live count never exceeds the capacity.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("live count above capacity");

    // Placing an inserted value grows the count by exactly one.
    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INS_PUT |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("insert did not grow the count");

    // Finishing a delete shrinks the count by exactly one.
    a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEL_RD && ptr_inc >= cnt_reg)
        |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("delete did not shrink the count");

    // Traverse and search only read live entries.
    a_live_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TRV_RD || state_reg == S_SRCH_RD) |-> ptr_reg < cnt_reg)
        else $error("read past the live entries");

endmodule

### rtl/array_insert_delete_search.sv
// ----------------------------------------------------------------------------
// array_insert_delete_search
// Packed array of signed words with insert, delete by value, search and
// traverse operations.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on the in_valid/in_ready channel with opcode, value and
// position; results leave on out_valid/out_ready with status, index,
// element, count and last. Insert, delete and search give one result beat
// with last set; traverse gives one beat per live entry, last on the final
// one, or a single empty-status beat when the array holds nothing.
// A two-entry command queue sits ahead of the execution engine, so up to two
// commands are taken while an earlier one is still being worked on.
// The engine uses one memory read and one write port, so work is serial.
// Insert shifts the entries above the slot up and then places the value,
// delete scans for the value and then shifts the later entries down, search
// scans, and traverse reads each live entry in order; every command first
// passes through the queue. Reset empties the array at once; no clearing
// pass is needed. When the receiver stalls, the current result holds in the
// output register and the engine waits; the queue keeps accepting until it
// fills.
// ----------------------------------------------------------------------------
module array_insert_delete_search
    import aids_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [OPC_W-1:0]          opcode,
    input  logic signed [DATA_W-1:0]  value,
    input  logic [POS_W-1:0]          position,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [STAT_W-1:0]         status,
    output logic [INDEX_W-1:0]        index,
    output logic signed [DATA_W-1:0]  element,
    output logic [COUNT_W-1:0]        count,
    output logic                      last
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // Front part: accept and decode commands.
    aids_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .value     (value),
        .position  (position),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Back part: execute commands and produce result beats.
    aids_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .index     (index),
        .element   (element),
        .count     (count),
        .last      (last)
    );

endmodule
